@@ rtl/ldm_pkg.sv @@
`timescale 1ns / 1ps

package ldm_pkg;

   // Request opcodes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Fixed 3-bit fields of the request and response
   typedef logic [2:0] coord_type;
   typedef logic [2:0] level_type;

endpackage

@@ rtl/ldm_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module ldm_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 35
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/led_dot_matrix_grey_scan.sv @@
`timescale 1ns / 1ps

// LED dot matrix grey-scale scanner. Drives a COLUMNS x ROWS matrix one dot
// per tick: a tick request (opcode OP_TICK) returns the column and row being
// driven, whether that dot is lit in the current PWM slot (lit when its grey
// level is greater than the slot, slots run 0..PWM_SLOTS-1), and a flag on the
// tick that finishes the last slot of the last row of a column. After each
// tick the slot advances, then the row, then the column. A write request
// (opcode OP_WRITE) sets one dot's 3-bit level and returns nothing; writes to
// a column or row outside the matrix are dropped. All dots read as dark after
// reset; a per-dot valid bit covers this, so there is no clearing pass and the
// block takes requests from the first cycle after reset. Rate is one request
// per clock in both directions while req_stall is low. A tick's response passes
// through the registered read of the level store in the read stage, then the
// compare into the response register. A write is visible to a tick that
// transfers in the very next cycle. Backpressure on rsp_ reaches req_stall
// only when both the read stage and the response register are full.
module led_dot_matrix_grey_scan #(
   parameter int COLUMNS   = 5,
   parameter int ROWS      = 7,
   parameter int PWM_SLOTS = 7
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  ldm_pkg::coord_type req_write_column,
   input  ldm_pkg::coord_type req_write_row,
   input  ldm_pkg::level_type req_write_level,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ldm_pkg::coord_type rsp_column_index,
   output ldm_pkg::coord_type rsp_row_index,
   output logic               rsp_dot_on,
   output logic               rsp_column_done
);

   import ldm_pkg::*;

   localparam int DEPTH = COLUMNS * ROWS;
   localparam int AW    = (DEPTH > 1)     ? $clog2(DEPTH)     : 1;
   localparam int CW    = (COLUMNS > 1)   ? $clog2(COLUMNS)   : 1;
   localparam int RW    = (ROWS > 1)      ? $clog2(ROWS)      : 1;
   localparam int SW    = (PWM_SLOTS > 1) ? $clog2(PWM_SLOTS) : 1;

   // ---------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------
   logic req_xfer;
   logic tick_xfer;
   logic wr_xfer;
   logic out_adv;       // response register can take a new entry

   logic rsp_vld_ff, rsp_vld_in;
   logic s1_vld_ff,  s1_vld_in;

   assign out_adv   = !rsp_vld_ff || !rsp_stall;
   assign req_stall = s1_vld_ff && !out_adv;
   assign req_xfer  = req_valid && !req_stall;
   assign tick_xfer = req_xfer && (req_opcode == OP_TICK);
   assign wr_xfer   = req_xfer && (req_opcode == OP_WRITE);

   // ---------------------------------------------------------------
   // Scan counters. scan_addr tracks column * ROWS + row so the store
   // is addressed without a multiply.
   // ---------------------------------------------------------------
   logic [CW-1:0] scan_col_ff,  scan_col_in;
   logic [RW-1:0] scan_row_ff,  scan_row_in;
   logic [SW-1:0] pwm_slot_ff,  pwm_slot_in;
   logic [AW-1:0] scan_addr_ff, scan_addr_in;

   logic slot_last;
   logic row_last;
   logic col_last;
   logic tick_done;

   assign slot_last = (pwm_slot_ff == SW'(PWM_SLOTS - 1));
   assign row_last  = (scan_row_ff == RW'(ROWS - 1));
   assign col_last  = (scan_col_ff == CW'(COLUMNS - 1));
   assign tick_done = slot_last && row_last;

   always_comb begin
      scan_col_in  = scan_col_ff;
      scan_row_in  = scan_row_ff;
      pwm_slot_in  = pwm_slot_ff;
      scan_addr_in = scan_addr_ff;
      if (tick_xfer) begin
         if (!slot_last) begin
            pwm_slot_in = pwm_slot_ff + SW'(1);
         end else begin
            pwm_slot_in = '0;
            if (!row_last) begin
               scan_row_in  = scan_row_ff + RW'(1);
               scan_addr_in = scan_addr_ff + AW'(1);
            end else begin
               scan_row_in = '0;
               if (!col_last) begin
                  scan_col_in  = scan_col_ff + CW'(1);
                  scan_addr_in = scan_addr_ff + AW'(1);
               end else begin
                  scan_col_in  = '0;
                  scan_addr_in = '0;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Level store with per-dot valid bits (invalid reads as dark)
   // ---------------------------------------------------------------
   logic             wr_in_range;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   level_type        rd_level;
   logic [DEPTH-1:0] dot_vld_ff, dot_vld_in;

   assign wr_in_range = (32'(req_write_column) < 32'(COLUMNS))
                     && (32'(req_write_row) < 32'(ROWS));
   assign wr_en       = wr_xfer && wr_in_range;
   assign wr_addr     = AW'(32'(req_write_column) * ROWS + 32'(req_write_row));

   always_comb begin
      dot_vld_in = dot_vld_ff;
      if (wr_en) begin
         dot_vld_in[wr_addr] = 1'b1;
      end
   end

   ldm_ram #(
      .WIDTH (3),
      .DEPTH (DEPTH)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_write_level),
      .rd_en   (tick_xfer),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_level)
   );

   // ---------------------------------------------------------------
   // Read stage: holds the tick's scan position while the level is read
   // ---------------------------------------------------------------
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   logic [SW-1:0] s1_slot_ff;
   logic          s1_dot_vld_ff;
   logic          s1_done_ff;
   logic          s1_lit;

   assign s1_vld_in = tick_xfer || (s1_vld_ff && !out_adv);
   assign s1_lit    = s1_dot_vld_ff && (32'(rd_level) > 32'(s1_slot_ff));

   // ---------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------
   coord_type rsp_col_ff;
   coord_type rsp_row_ff;
   logic      rsp_lit_ff;
   logic      rsp_done_ff;

   assign rsp_vld_in = out_adv ? s1_vld_ff : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_col_ff  <= '0;
         scan_row_ff  <= '0;
         pwm_slot_ff  <= '0;
         scan_addr_ff <= '0;
         dot_vld_ff   <= '0;
         s1_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         scan_col_ff  <= scan_col_in;
         scan_row_ff  <= scan_row_in;
         pwm_slot_ff  <= pwm_slot_in;
         scan_addr_ff <= scan_addr_in;
         dot_vld_ff   <= dot_vld_in;
         s1_vld_ff    <= s1_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_xfer) begin
         s1_col_ff     <= scan_col_ff;
         s1_row_ff     <= scan_row_ff;
         s1_slot_ff    <= pwm_slot_ff;
         s1_dot_vld_ff <= dot_vld_ff[scan_addr_ff];
         s1_done_ff    <= tick_done;
      end
      if (s1_vld_ff && out_adv) begin
         rsp_col_ff  <= 3'(s1_col_ff);
         rsp_row_ff  <= 3'(s1_row_ff);
         rsp_lit_ff  <= s1_lit;
         rsp_done_ff <= s1_done_ff;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_column_index = rsp_col_ff;
   assign rsp_row_index    = rsp_row_ff;
   assign rsp_dot_on       = rsp_lit_ff;
   assign rsp_column_done  = rsp_done_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------

   // scan address always matches column * ROWS + row
   assert property (@(posedge clock) disable iff (reset)
      32'(scan_addr_ff) == 32'(scan_col_ff) * ROWS + 32'(scan_row_ff))
      else $error("scan address out of step with column/row counters");

   // a column-done flag only on the last slot of the last row
   assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s1_done_ff) |->
         (s1_row_ff == RW'(ROWS - 1)) && (s1_slot_ff == SW'(PWM_SLOTS - 1)))
      else $error("column done flagged mid-column");

   // an in-range write marks its dot as written
   assert property (@(posedge clock) disable iff (reset)
      wr_en |=> dot_vld_ff[$past(wr_addr)])
      else $error("dot valid bit not set by write");

   // a tick transfer always lands in the read stage
   assert property (@(posedge clock) disable iff (reset)
      tick_xfer |=> s1_vld_ff)
      else $error("tick lost between request and read stage");

endmodule
